// ===== rtl/tcsb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsb_pkg
// Shared types, codes and defaults of the text console scrollback buffer.
// ----------------------------------------------------------------------------
package tcsb_pkg;

    // Default geometry
    localparam int LINES_DEF    = 128;
    localparam int COLS_DEF     = 53;
    localparam int VIS_ROWS_DEF = 24;

    // Field widths of the channels
    localparam int REQ_W    = 3;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int LINE_W   = 7;
    localparam int COL_W    = 6;
    localparam int CURSOR_W = 6;
    localparam int TOTAL_W  = 8;
    localparam int SCROLL_W = 7;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUT         = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SCROLL_UP   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SCROLL_DOWN = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LEAVE       = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR       = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ        = 3'd5;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NL = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] char_color;
        logic [LINE_W-1:0]  line_index;
        logic [COL_W-1:0]   column;
    } t_req;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_col;
        logic [TOTAL_W-1:0]  line_total;
        logic [SCROLL_W-1:0] scroll_back;
        logic [CHAR_W-1:0]   cell_char;
        logic [COLOR_W-1:0]  cell_color;
    } t_rsp;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] color;
    } t_cell;

    // Updates of the cursor, line and scroll registers
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADVANCE,
        OP_CR,
        OP_BS,
        OP_OPEN,
        OP_SCROLL_UP,
        OP_SCROLL_DOWN,
        OP_RESET
    } t_state_op;

    // Column source of a cell address
    typedef enum logic [1:0] {
        COL_CURSOR,
        COL_CURSOR_DEC,
        COL_READ,
        COL_ZERO
    } t_col_sel;

    typedef struct packed {
        logic      latch;
        logic      row_calc;
        logic      row_line;
        logic      addr_calc;
        t_col_sel  col_sel;
        logic      mem_wr;
        logic      wr_zero;
        logic      mem_rd;
        logic      rd_clear;
        logic      clr_step;
        logic      scroll_zero;
        t_state_op op;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             is_nl;
        logic             is_cr;
        logic             is_bs;
        logic             cursor_zero;
        logic             cursor_last;
        logic             read_ok;
        logic             clr_done;
    } t_dp_stat;

endpackage

// ===== rtl/tcsb_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsb_chan_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface tcsb_chan_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/tcsb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsb_datapath
// Cell memory, ring pointers, cursor and scroll registers, address unit and
// result register, driven by commands from the controller.
// ----------------------------------------------------------------------------
module tcsb_datapath #(
    parameter int LINES        = tcsb_pkg::LINES_DEF,
    parameter int COLS         = tcsb_pkg::COLS_DEF,
    parameter int VISIBLE_ROWS = tcsb_pkg::VIS_ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcsb_pkg::t_req     i_req_data,
    input  tcsb_pkg::t_dp_cmd  i_cmd,
    output tcsb_pkg::t_dp_stat o_stat,
    output tcsb_pkg::t_rsp     o_rsp_data
);
    import tcsb_pkg::*;

    localparam int LW    = $clog2(LINES);
    localparam int UW    = $clog2(LINES + 1);
    localparam int CW    = $clog2(COLS);
    localparam int DEPTH = LINES * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = (UW > LINE_W) ? UW : LINE_W;
    localparam int CKW   = (CW + 1 > COL_W) ? CW + 1 : COL_W;
    localparam int VRW   = $clog2(VISIBLE_ROWS + 1);
    localparam int VW    = (UW > VRW) ? UW : VRW;

    t_req          r_req;
    logic [LW-1:0] r_oldest, n_oldest;
    logic [UW-1:0] r_used,   n_used;
    logic [CW-1:0] r_cursor, n_cursor;
    logic [UW-1:0] r_scroll, n_scroll;
    logic [LW-1:0] r_row;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_clr_cnt;
    t_cell         r_rd;
    t_rsp          r_rsp;
    t_cell         r_mem [DEPTH];

    logic [LW-1:0] logical;
    logic [LW:0]   row_sum;
    logic [LW:0]   row_wrap;
    logic [CW-1:0] col_idx;
    logic [AW-1:0] n_addr;
    logic          can_scroll_up;

    // Hold the request fields for the whole operation
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req_data;
        end
    end

    // Logical line to physical ring row
    assign logical  = i_cmd.row_line ? LW'(r_req.line_index) : LW'(r_used - UW'(1));
    assign row_sum  = {1'b0, r_oldest} + {1'b0, logical};
    assign row_wrap = (row_sum >= (LW + 1)'(LINES)) ? row_sum - (LW + 1)'(LINES) : row_sum;

    always_comb begin
        case (i_cmd.col_sel)
            COL_CURSOR:     col_idx = r_cursor;
            COL_CURSOR_DEC: col_idx = r_cursor - CW'(1);
            COL_READ:       col_idx = CW'(r_req.column);
            default:        col_idx = '0;
        endcase
    end

    assign n_addr = AW'(r_row) * AW'(COLS) + AW'(col_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_calc) begin
            r_row <= LW'(row_wrap);
        end
        if (i_cmd.addr_calc) begin
            r_addr    <= n_addr;
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_addr    <= r_addr + AW'(1);
            r_clr_cnt <= r_clr_cnt + CW'(1);
        end
    end

    // Cell memory, one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[r_addr] <= i_cmd.wr_zero ? t_cell'('0) : t_cell'({r_req.char_code,
                                                                     r_req.char_color});
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_mem[r_addr];
        end else if (i_cmd.rd_clear) begin
            r_rd <= '0;
        end
    end

    assign can_scroll_up = (VW'(r_used) > VW'(VISIBLE_ROWS)) &&
                           (VW'(r_scroll) < VW'(r_used) - VW'(VISIBLE_ROWS));

    always_comb begin
        n_oldest = r_oldest;
        n_used   = r_used;
        n_cursor = r_cursor;
        n_scroll = r_scroll;
        case (i_cmd.op)
            OP_ADVANCE: n_cursor = o_stat.cursor_last ? '0 : r_cursor + CW'(1);
            OP_CR:      n_cursor = '0;
            OP_BS:      n_cursor = r_cursor - CW'(1);
            OP_OPEN: begin
                n_cursor = '0;
                if (r_used < UW'(LINES)) begin
                    n_used = r_used + UW'(1);
                end else begin
                    // Ring is full: drop the oldest line
                    n_oldest = (r_oldest == LW'(LINES - 1)) ? '0 : r_oldest + LW'(1);
                end
            end
            OP_SCROLL_UP: begin
                if (can_scroll_up) begin
                    n_scroll = r_scroll + UW'(1);
                end
            end
            OP_SCROLL_DOWN: begin
                if (r_scroll != '0) begin
                    n_scroll = r_scroll - UW'(1);
                end
            end
            OP_RESET: begin
                n_oldest = '0;
                n_used   = UW'(1);
                n_cursor = '0;
                n_scroll = '0;
            end
            default: ;
        endcase
        if (i_cmd.scroll_zero) begin
            n_scroll = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_used   <= UW'(1);
            r_cursor <= '0;
            r_scroll <= '0;
        end else begin
            r_oldest <= n_oldest;
            r_used   <= n_used;
            r_cursor <= n_cursor;
            r_scroll <= n_scroll;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rsp.cursor_col  <= CURSOR_W'(r_cursor);
            r_rsp.line_total  <= TOTAL_W'(r_used);
            r_rsp.scroll_back <= SCROLL_W'(r_scroll);
            r_rsp.cell_char   <= r_rd.ch;
            r_rsp.cell_color  <= r_rd.color;
        end
    end

    assign o_rsp_data = r_rsp;

    assign o_stat.req_type    = r_req.req_type;
    assign o_stat.is_nl       = (r_req.char_code == CH_NL);
    assign o_stat.is_cr       = (r_req.char_code == CH_CR);
    assign o_stat.is_bs       = (r_req.char_code == CH_BS);
    assign o_stat.cursor_zero = (r_cursor == '0);
    assign o_stat.cursor_last = (r_cursor == CW'(COLS - 1));
    assign o_stat.read_ok     = (KW'(r_req.line_index) < KW'(r_used)) &&
                                (CKW'(r_req.column) < CKW'(COLS));
    assign o_stat.clr_done    = (r_clr_cnt == CW'(COLS - 1));

endmodule

// ===== rtl/tcsb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsb_ctrl
// Request sequencer: decodes a request, steps the datapath through row,
// address, memory and line-clearing phases, and owns the output valid.
// ----------------------------------------------------------------------------
module tcsb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  tcsb_pkg::t_dp_stat i_stat,
    output tcsb_pkg::t_dp_cmd  o_cmd
);
    import tcsb_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_WROW   = 4'd2;
    localparam logic [3:0] S_WADDR  = 4'd3;
    localparam logic [3:0] S_WRITE  = 4'd4;
    localparam logic [3:0] S_OPEN   = 4'd5;
    localparam logic [3:0] S_CROW   = 4'd6;
    localparam logic [3:0] S_CADDR  = 4'd7;
    localparam logic [3:0] S_CLEAR  = 4'd8;
    localparam logic [3:0] S_RROW   = 4'd9;
    localparam logic [3:0] S_RADDR  = 4'd10;
    localparam logic [3:0] S_READ   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_boot,  n_boot;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_boot      = r_boot;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.rd_clear = 1'b1;
                n_state        = S_DONE;
                case (i_stat.req_type)
                    REQ_PUT: begin
                        o_cmd.scroll_zero = 1'b1;
                        if (i_stat.is_nl) begin
                            n_state = S_OPEN;
                        end else if (i_stat.is_cr) begin
                            o_cmd.op = OP_CR;
                        end else if (!(i_stat.is_bs && i_stat.cursor_zero)) begin
                            n_state = S_WROW;
                        end
                    end
                    REQ_SCROLL_UP:   o_cmd.op = OP_SCROLL_UP;
                    REQ_SCROLL_DOWN: o_cmd.op = OP_SCROLL_DOWN;
                    REQ_LEAVE:       o_cmd.scroll_zero = 1'b1;
                    REQ_CLEAR: begin
                        o_cmd.op = OP_RESET;
                        n_state  = S_CROW;
                    end
                    REQ_READ: begin
                        if (i_stat.read_ok) begin
                            n_state = S_RROW;
                        end
                    end
                    default: ;
                endcase
            end
            S_WROW: begin
                o_cmd.row_calc = 1'b1;
                n_state        = S_WADDR;
            end
            S_WADDR: begin
                o_cmd.addr_calc = 1'b1;
                o_cmd.col_sel   = i_stat.is_bs ? COL_CURSOR_DEC : COL_CURSOR;
                n_state         = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.mem_wr  = 1'b1;
                o_cmd.wr_zero = i_stat.is_bs;
                o_cmd.op      = i_stat.is_bs ? OP_BS : OP_ADVANCE;
                // Wrap at the last column opens a new line
                n_state = (!i_stat.is_bs && i_stat.cursor_last) ? S_OPEN : S_DONE;
            end
            S_OPEN: begin
                o_cmd.op = OP_OPEN;
                n_state  = S_CROW;
            end
            S_CROW: begin
                o_cmd.row_calc = 1'b1;
                n_state        = S_CADDR;
            end
            S_CADDR: begin
                o_cmd.addr_calc = 1'b1;
                o_cmd.col_sel   = COL_ZERO;
                n_state         = S_CLEAR;
            end
            S_CLEAR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.wr_zero  = 1'b1;
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    // The power-up sweep produces no result
                    n_state = r_boot ? S_IDLE : S_DONE;
                    n_boot  = 1'b0;
                end
            end
            S_RROW: begin
                o_cmd.row_calc = 1'b1;
                o_cmd.row_line = 1'b1;
                n_state        = S_RADDR;
            end
            S_RADDR: begin
                o_cmd.addr_calc = 1'b1;
                o_cmd.col_sel   = COL_READ;
                n_state         = S_READ;
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CROW;
            r_boot      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_boot      <= n_boot;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/text_console_scrollback_buffer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_scrollback_buffer_core
// Character-cell console history of LINES lines by COLS cells, kept as a ring.
//
// Channels: i_req takes one request per transfer (put char, scroll up,
// scroll down, leave scrollback, clear, read cell); o_rsp returns exactly one
// result per request with cursor column, lines in use, scroll offset and,
// for a read, the cell character and color.
// Path to result: scroll, leave, carriage return, backspace at column 0 and
// out-of-range reads go from decode to done; a stored character or backspace
// passes row, address and write states, a read cell row, address and read.
// A clear runs row, address and clear states, zeroing a line one cell per cycle
// through the single memory write port; opening a line (newline, wrap) adds open.
// One request is processed at a time; a new one is taken once the previous
// result sits in the output register, so a stalled receiver holds only that
// finished result, and blocks the next one from leaving the sequencer.
// Reset: after i_rst_n releases, physical line 0 is swept to zero with
// i_req.ready low; the store then holds one empty line.
// ----------------------------------------------------------------------------
module text_console_scrollback_buffer_core #(
    parameter int LINES        = tcsb_pkg::LINES_DEF,
    parameter int COLS         = tcsb_pkg::COLS_DEF,
    parameter int VISIBLE_ROWS = tcsb_pkg::VIS_ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcsb_chan_if.sink   i_req,
    tcsb_chan_if.source o_rsp
);
    import tcsb_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    t_rsp     rsp_data;
    logic     in_ready;
    logic     out_valid;

    tcsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    tcsb_datapath #(
        .LINES        (LINES),
        .COLS         (COLS),
        .VISIBLE_ROWS (VISIBLE_ROWS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_data (i_req.data),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_rsp_data (rsp_data)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = rsp_data;

    // One memory port: never write and read in the same cycle
    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dp_cmd.mem_wr && dp_cmd.mem_rd))
        else $error("cell memory written and read in the same cycle");

    // A request transfer starts a sequence; no second request next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while previous one is in flight");

    // Result register is only loaded when free or being drained
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result overwritten before transfer");

    // A cell is only read for an in-range read request
    a_read_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.mem_rd |-> (dp_stat.read_ok && dp_stat.req_type == REQ_READ))
        else $error("cell read outside an in-range read request");

endmodule

// ===== tb/text_console_scrollback_buffer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_scrollback_buffer_core_tb
// Self-checking bench for the console scrollback store. A mirror of the cell
// history, cursor, line ring and scroll offset predicts every response; a
// short directed pass hits the edge cases, then random text, newline runs,
// scroll bursts, reads and noise fill and wrap the ring under random
// request gaps and response back-pressure.
// ----------------------------------------------------------------------------
module text_console_scrollback_buffer_core_tb;
    import tcsb_pkg::*;

    localparam int TARGET_ITEMS   = 1350;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int LONG_HOLD      = 600;
    localparam int HOLD_AT_RESULT = 400;
    localparam int PAUSE_AT_ITEM  = 700;

    // Request codes the block ignores
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    class console_mirror;
        bit [CHAR_W-1:0]   cell_ch [LINES_DEF*COLS_DEF];
        bit [COLOR_W-1:0]  cell_co [LINES_DEF*COLS_DEF];
        bit [LINE_W-1:0]   oldest;
        bit [TOTAL_W-1:0]  used;
        bit [CURSOR_W-1:0] cur;
        bit [SCROLL_W-1:0] scroll;
        t_rsp pending_replies[$];
        int errors;
        int checked;
        int opened;
        int dropped;
        int reads_hit;
        int max_scroll;

        function new();
            wipe();
            errors     = 0;
            checked    = 0;
            opened     = 0;
            dropped    = 0;
            reads_hit  = 0;
            max_scroll = 0;
        endfunction

        function void wipe();
            foreach (cell_ch[i]) begin
                cell_ch[i] = '0;
                cell_co[i] = '0;
            end
            oldest = '0;
            used   = 1;
            cur    = '0;
            scroll = '0;
        endfunction

        function int row_base(int logical);
            return ((int'(oldest) + logical) % LINES_DEF) * COLS_DEF;
        endfunction

        // Grow the history or drop the oldest line, then blank the newest one
        function void open_line();
            int base;
            cur = '0;
            if (used < LINES_DEF) begin
                used++;
            end else begin
                oldest = LINE_W'((int'(oldest) + 1) % LINES_DEF);
                dropped++;
            end
            opened++;
            base = row_base(int'(used) - 1);
            for (int i = 0; i < COLS_DEF; i++) begin
                cell_ch[base + i] = '0;
                cell_co[base + i] = '0;
            end
        endfunction

        function void put(t_req r);
            int base;
            base = row_base(int'(used) - 1);
            if (r.char_code == CH_NL) begin
                open_line();
            end else if (r.char_code == CH_CR) begin
                cur = '0;
            end else if (r.char_code == CH_BS) begin
                if (cur != 0) begin
                    cur--;
                    cell_ch[base + cur] = '0;
                    cell_co[base + cur] = '0;
                end
            end else begin
                cell_ch[base + cur] = r.char_code;
                cell_co[base + cur] = r.char_color;
                cur++;
                if (cur >= COLS_DEF) open_line();
            end
            scroll = '0;
        endfunction

        function void apply_request(t_req r);
            t_rsp want;
            int at;
            want = '0;
            case (r.req_type)
                REQ_PUT: begin
                    put(r);
                end
                REQ_SCROLL_UP: begin
                    if (used > VIS_ROWS_DEF && scroll < used - VIS_ROWS_DEF) scroll++;
                end
                REQ_SCROLL_DOWN: begin
                    if (scroll != 0) scroll--;
                end
                REQ_LEAVE: begin
                    scroll = '0;
                end
                REQ_CLEAR: begin
                    wipe();
                end
                REQ_READ: begin
                    if (r.line_index < used && r.column < COLS_DEF) begin
                        at = row_base(int'(r.line_index)) + int'(r.column);
                        want.cell_char  = cell_ch[at];
                        want.cell_color = cell_co[at];
                        reads_hit++;
                    end
                end
                default: begin
                end
            endcase
            if (int'(scroll) > max_scroll) max_scroll = int'(scroll);
            want.cursor_col  = cur;
            want.line_total  = used;
            want.scroll_back = scroll;
            pending_replies.push_back(want);
        endfunction

        function void field_check(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_reply(t_rsp got);
            t_rsp want;
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: response with nothing outstanding, expected none, got %h",
                         $time, got);
                return;
            end
            want = pending_replies.pop_front();
            checked++;
            field_check("cursor_col", 8'(want.cursor_col), 8'(got.cursor_col));
            field_check("line_total", want.line_total, got.line_total);
            field_check("scroll_back", 8'(want.scroll_back), 8'(got.scroll_back));
            field_check("cell_char", want.cell_char, got.cell_char);
            field_check("cell_color", want.cell_color, got.cell_color);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcsb_chan_if #(.t_data(t_req)) req_if ();
    tcsb_chan_if #(.t_data(t_rsp)) rsp_if ();

    console_mirror mirror = new();
    int  sent = 0;
    bit  sender_steady = 1'b0;
    bit  receiver_steady = 1'b0;

    always #2 i_clk = ~i_clk;

    text_console_scrollback_buffer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Track every transfer on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) mirror.apply_request(req_if.data);
            if (rsp_if.valid && rsp_if.ready) mirror.check_reply(rsp_if.data);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** text_console_scrollback_buffer_core: FAILED **");
        $finish;
    end

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_byte();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    initial begin : receiver
        int taken;
        int gap;
        bit held;
        taken = 0;
        held  = 1'b0;
        rsp_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (taken == HOLD_AT_RESULT && !held) begin
                // Hold off long enough for the request side to back up
                held = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                gap = receiver_steady ? 0 : idle_gap();
                if (gap > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            taken++;
            if (taken % 64 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
        end
    end

    task automatic send_request(input t_req r);
        int gap;
        gap = sender_steady ? 0 : idle_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        sent++;
    endtask

    function automatic t_req any_req(input logic [REQ_W-1:0] kind);
        t_req r;
        r.req_type   = kind;
        r.char_code  = rand_byte();
        r.char_color = rand_byte();
        r.line_index = LINE_W'($urandom_range(0, 127));
        r.column     = COL_W'($urandom_range(0, 63));
        return r;
    endfunction

    task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [COLOR_W-1:0] color);
        t_req r;
        r = any_req(REQ_PUT);
        r.char_code  = ch;
        r.char_color = color;
        send_request(r);
    endtask

    task automatic read_cell(input logic [LINE_W-1:0] line, input logic [COL_W-1:0] col);
        t_req r;
        r = any_req(REQ_READ);
        r.line_index = line;
        r.column     = col;
        send_request(r);
    endtask

    task automatic plain_req(input logic [REQ_W-1:0] kind);
        send_request(any_req(kind));
    endtask

    task automatic wait_for_replies();
        req_if.valid <= 1'b0;
        // Let the mirror take the last accepted request first
        @(posedge i_clk);
        while (mirror.pending_replies.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int kind;
        int n;
        int roll;
        bit paused;
        logic [CHAR_W-1:0] ch;
        t_req r;
        paused = 1'b0;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed edge cases
        read_cell(0, 0);
        put_char(8'h41, 8'hFF);
        put_char(8'hFF, 8'h00);
        put_char(8'h00, 8'hA5);
        read_cell(0, 0);
        read_cell(0, 1);
        put_char(CH_BS, rand_byte());
        read_cell(0, 2);
        put_char(CH_CR, rand_byte());
        put_char(CH_BS, rand_byte());
        read_cell(0, 52);
        read_cell(0, 53);
        read_cell(7'h7F, 6'h3F);
        read_cell(1, 0);
        put_char(CH_NL, rand_byte());
        plain_req(REQ_SCROLL_UP);
        plain_req(REQ_SCROLL_DOWN);
        plain_req(REQ_LEAVE);
        plain_req(REQ_SPARE_6);
        plain_req(REQ_SPARE_7);
        read_cell(0, 1);
        plain_req(REQ_CLEAR);
        read_cell(0, 0);

        while (sent < TARGET_ITEMS) begin
            if (!paused && sent >= PAUSE_AT_ITEM) begin
                paused = 1'b1;
                wait_for_replies();
            end
            sender_steady = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 28) begin
                // A line of text, with the odd backspace and return mixed in
                n = $urandom_range(1, 70);
                repeat (n) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 6) ch = CH_BS;
                    else if (roll < 8) ch = CH_CR;
                    else ch = rand_byte();
                    put_char(ch, rand_byte());
                end
                if ($urandom_range(0, 9) < 7) put_char(CH_NL, rand_byte());
            end else if (kind < 46) begin
                repeat ($urandom_range(5, 40)) put_char(CH_NL, rand_byte());
            end else if (kind < 50) begin
                // A run of newlines near the ring depth, to fill and rotate the ring
                repeat ($urandom_range(90, 140)) put_char(CH_NL, rand_byte());
            end else if (kind < 64) begin
                repeat ($urandom_range(1, 120)) plain_req(REQ_SCROLL_UP);
                repeat ($urandom_range(0, 30)) plain_req(REQ_SCROLL_DOWN);
                if ($urandom_range(0, 1) == 0) plain_req(REQ_LEAVE);
            end else if (kind < 82) begin
                repeat ($urandom_range(1, 20)) begin
                    r = any_req(REQ_READ);
                    if ($urandom_range(0, 99) < 85)
                        r.line_index = LINE_W'($urandom_range(0, int'(mirror.used) - 1));
                    if ($urandom_range(0, 99) < 85)
                        r.column = COL_W'($urandom_range(0, COLS_DEF - 1));
                    send_request(r);
                end
            end else if (kind < 97) begin
                repeat ($urandom_range(1, 10)) begin
                    r = any_req(REQ_W'($urandom_range(0, 7)));
                    // Keep clears rare so the history gets deep
                    if (r.req_type == REQ_CLEAR && $urandom_range(0, 9) != 0)
                        r.req_type = REQ_READ;
                    send_request(r);
                end
            end else begin
                plain_req(REQ_CLEAR);
            end
        end

        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests, %0d responses checked, %0d lines opened, %0d dropped",
                 sent, mirror.checked, mirror.opened, mirror.dropped);
        $display("Deepest scroll %0d, %0d in-range reads, %0d mismatches",
                 mirror.max_scroll, mirror.reads_hit, mirror.errors);
        if (mirror.errors == 0 && mirror.pending_replies.size() == 0) begin
            $display("** text_console_scrollback_buffer_core: PASSED **");
        end else begin
            $display("%0t: %0d responses still outstanding", $time,
                     mirror.pending_replies.size());
            $display("** text_console_scrollback_buffer_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tcsb_pkg.sv
rtl/tcsb_chan_if.sv
rtl/tcsb_datapath.sv
rtl/tcsb_ctrl.sv
rtl/text_console_scrollback_buffer_core.sv
tb/text_console_scrollback_buffer_core_tb.sv
